// ===== rtl/rdsrt_pkg.sv =====
// Shared types, constants and helpers for the RDS radiotext assembler.
package rdsrt_pkg;

  localparam int unsigned TEXT_LENGTH   = 64;
  localparam int unsigned CHARS_PER_ROW = 4;
  localparam int unsigned NUM_ROWS      = TEXT_LENGTH / CHARS_PER_ROW;
  localparam int unsigned ROW_W         = $clog2(NUM_ROWS);
  localparam int unsigned COL_W         = $clog2(CHARS_PER_ROW);
  localparam int unsigned ROW_BITS      = 8 * CHARS_PER_ROW;
  localparam int unsigned GROUP_LSB     = 11;

  localparam logic [4:0] GRP_2A     = 5'd4;
  localparam logic [4:0] GRP_2B     = 5'd5;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] MAX_PRINT  = 8'd126;
  localparam logic [ROW_BITS-1:0] SPACE_ROW = {CHARS_PER_ROW{SPACE_CHAR}};

  typedef enum logic [1:0] {
    OP_GROUP  = 2'd0,
    OP_RETUNE = 2'd1,
    OP_READ   = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic       text_ready;
    logic [7:0] read_char;
  } out_item_t;

  // Decoded control for one transaction, handed from decode to the text store.
  typedef struct packed {
    logic                write_seg;
    logic                wrap;
    logic                retune;
    logic                read;
    logic [ROW_W-1:0]    seg;
    logic [ROW_BITS-1:0] new_row;
    logic [ROW_W-1:0]    read_row;
    logic [COL_W-1:0]    read_col;
  } ctrl_t;

  function automatic logic [7:0] printable(input logic [7:0] ch);
    if (ch < SPACE_CHAR || ch > MAX_PRINT) begin
      return SPACE_CHAR;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/rdsrt_decode.sv =====
// Decodes one registered transaction into text store control.
module rdsrt_decode (
  input  rdsrt_pkg::in_item_t item_i,
  output rdsrt_pkg::ctrl_t    ctrl_o
);
  import rdsrt_pkg::*;

  logic [4:0] group_code;
  logic       is_text_group;

  assign group_code    = item_i.block_b[GROUP_LSB +: 5];
  assign is_text_group = (item_i.opcode == OP_GROUP) &&
                         (group_code == GRP_2A || group_code == GRP_2B);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.seg       = item_i.block_b[ROW_W-1:0];
    ctrl_o.write_seg = is_text_group;
    ctrl_o.wrap      = is_text_group && (item_i.block_b[ROW_W-1:0] == '0);
    ctrl_o.retune    = (item_i.opcode == OP_RETUNE);
    ctrl_o.read      = (item_i.opcode == OP_READ);
    ctrl_o.new_row   = {printable(item_i.block_c[15:8]), printable(item_i.block_c[7:0]),
                        printable(item_i.block_d[15:8]), printable(item_i.block_d[7:0])};
    ctrl_o.read_row  = item_i.read_index[COL_W +: ROW_W];
    ctrl_o.read_col  = item_i.read_index[COL_W-1:0];
  end

endmodule

// ===== rtl/rdsrt_text_store.sv =====
// Current and last radiotext rows, waiting flag and result formation.
module rdsrt_text_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rdsrt_pkg::ctrl_t     ctrl_i,
  output rdsrt_pkg::out_item_t result_o,
  output logic                 waiting_o
);
  import rdsrt_pkg::*;

  logic [ROW_BITS-1:0] cur_q  [NUM_ROWS];
  logic [ROW_BITS-1:0] last_q [NUM_ROWS];
  logic                waiting_q;
  logic [ROW_BITS-1:0] last_row;
  logic [7:0]          last_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        cur_q[r]  <= SPACE_ROW;
        last_q[r] <= SPACE_ROW;
      end
      waiting_q <= 1'b1;
    end else if (en_i) begin
      if (ctrl_i.wrap) begin
        // segment zero: retire the whole text, then start a fresh one
        for (int r = 0; r < NUM_ROWS; r++) begin
          last_q[r] <= cur_q[r];
          cur_q[r]  <= (r == 0) ? ctrl_i.new_row : SPACE_ROW;
        end
        waiting_q <= 1'b0;
      end else if (ctrl_i.write_seg) begin
        cur_q[ctrl_i.seg] <= ctrl_i.new_row;
      end
      if (ctrl_i.retune) begin
        waiting_q <= 1'b1;
      end
    end
  end

  assign last_row = last_q[ctrl_i.read_row];

  always_comb begin
    case (ctrl_i.read_col)
      2'd0:    last_char = last_row[31:24];
      2'd1:    last_char = last_row[23:16];
      2'd2:    last_char = last_row[15:8];
      default: last_char = last_row[7:0];
    endcase
  end

  always_comb begin
    result_o.text_ready = ctrl_i.wrap && !waiting_q;
    result_o.read_char  = ctrl_i.read ? last_char : 8'd0;
  end

  assign waiting_o = waiting_q;

endmodule

// ===== rtl/rds_radiotext_assembler_unit.sv =====
// Top level of the RDS radiotext assembler: input register, decode, store, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  in      | sink      | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | source    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// One transaction per cycle when not stalled; input register, then result register.
// The input register feeds decode and the text store, whose update and result land
// together at the same edge, so each item sees the state left by the one before.
// Reset brings both texts to spaces and sets the waiting flag; no clearing pass.
// A stalled result holds the result register; one more item waits in the input register.
module rds_radiotext_assembler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rdsrt_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rdsrt_pkg::out_item_t out_data_o
);
  import rdsrt_pkg::*;

  logic      stage_valid_q;
  in_item_t  stage_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;
  logic      advance;
  ctrl_t     ctrl;
  out_item_t result;
  logic      waiting;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = stage_valid_q && out_free;
  assign in_stall_o = stage_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      stage_q <= in_data_i;
    end
  end

  rdsrt_decode u_decode (
    .item_i (stage_q),
    .ctrl_o (ctrl)
  );

  rdsrt_text_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .ctrl_i    (ctrl),
    .result_o  (result),
    .waiting_o (waiting)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_retune_sets_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ctrl.retune |=> waiting)
    else $error("retune did not set the waiting flag");

  a_ready_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.text_ready |-> out_q.read_char == 8'd0)
    else $error("text ready result carries a character");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid_q && out_valid_q)
    else $error("input stalled with nothing held");

  a_advance_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced transaction produced no result");
`endif

endmodule
